[rtl/wsd_pkg.sv]
// Shared widths, types and helpers for the WebSocket frame deframer.
package wsd_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned OPCODE_W = 4;

    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [OPCODE_W-1:0] opcode_t;

    // Opcodes that the protocol leaves unassigned
    localparam opcode_t OPC_RSVD_DATA_LO = 4'h3;
    localparam opcode_t OPC_RSVD_DATA_HI = 4'h7;
    localparam opcode_t OPC_RSVD_CTRL    = 4'hb;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    function automatic logic is_reserved_opcode(input opcode_t op);
        logic rsvd;
        begin
            case (op) inside
                [OPC_RSVD_DATA_LO:OPC_RSVD_DATA_HI], OPC_RSVD_CTRL: rsvd = 1'b1;
                default: rsvd = 1'b0;
            endcase
            return rsvd;
        end
    endfunction

endpackage

[rtl/wsd_if.sv]
// Stream interfaces: raw byte channel and decoded result channel.
interface wsd_byte_if;
    import wsd_pkg::*;

    logic  valid;
    logic  ready;
    data_t data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_result_if;
    import wsd_pkg::*;

    logic    valid;
    logic    ready;
    data_t   payload_byte;
    logic    byte_present;
    opcode_t message_opcode;
    logic    frame_end;
    logic    message_end;
    logic    protocol_error;

    modport source (output valid, output payload_byte, output byte_present,
                    output message_opcode, output frame_end, output message_end,
                    output protocol_error, input ready);
    modport sink   (input valid, input payload_byte, input byte_present,
                    input message_opcode, input frame_end, input message_end,
                    input protocol_error, output ready);
endinterface

[rtl/websocket_frame_deframer.sv]
// Streaming WebSocket frame deframer: header decode, unmasking, frame and message marks.
//
// Usage:
//   stream carries the received WebSocket byte stream, one word per handshake.
//   result carries one word per payload byte (unmasked, byte_present = 1), one
//   mark-only word (byte_present = 0, frame_end = 1) for a frame with an empty
//   payload, and a single word with protocol_error = 1 when a reserved opcode
//   (3..7 or 11) shows up in a first header byte. Header bytes give no word.
//   message_opcode is the opcode of the first fragment of the message;
//   message_end marks the last word of a frame with FIN set.
//   Timing: an accepted byte is held in the input register, and its result word
//   is loaded into the result register, from which it is valid on result.
//   Throughput: one byte per clock while the receiver does not stall; the header
//   decode, the 64-bit length count and the key XOR all settle between the input
//   register and the result register.
//   After a reserved opcode the block keeps taking bytes and drops them until
//   reset. Reset (rst_n low) returns the parser to the first header byte,
//   outside any message, and empties both registers.
//   When the receiver stalls, the result word holds; one more byte is parked in
//   the input register, then stream.ready drops until result.ready returns.
module websocket_frame_deframer #(
    parameter int unsigned LENGTH_BITS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    wsd_byte_if.sink     stream,
    wsd_result_if.source result
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    typedef logic [LENGTH_BITS-1:0] len_t;

    // Input register
    logic  in_valid_reg;
    data_t in_byte_reg;

    // Parser state
    logic [2:0]   phase_reg,     phase_next;
    logic [2:0]   hdr_cnt_reg,   hdr_cnt_next;
    logic         fin_reg,       fin_next;
    logic         masked_reg,    masked_next;
    logic         ext_long_reg,  ext_long_next;
    len_t         remain_reg,    remain_next;
    logic [31:0]  key_reg,       key_next;
    logic [1:0]   key_pos_reg,   key_pos_next;
    opcode_t      msg_opc_reg,   msg_opc_next;
    logic         in_msg_reg,    in_msg_next;
    logic         err_reg,       err_next;

    // Result register
    logic    res_valid_reg;
    data_t   res_byte_reg,    res_byte_next;
    logic    res_present_reg, res_present_next;
    opcode_t res_opc_reg,     res_opc_next;
    logic    res_fend_reg,    res_fend_next;
    logic    res_mend_reg,    res_mend_next;
    logic    res_err_reg,     res_err_next;
    logic    res_load;

    logic  out_free;
    logic  advance;
    len_t  ext_len;
    data_t key_byte;
    logic  len_zero;

    assign out_free     = !res_valid_reg || result.ready;
    assign advance      = in_valid_reg && out_free;
    assign stream.ready = !in_valid_reg || out_free;

    // Extended length: shift in one byte, saturate once the top byte is nonzero
    assign ext_len = (remain_reg[LENGTH_BITS-1 -: 8] != 8'd0) ? '1
                   : {remain_reg[LENGTH_BITS-9:0], in_byte_reg};

    always_comb
    begin
        case (key_pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        fin_next      = fin_reg;
        masked_next   = masked_reg;
        ext_long_next = ext_long_reg;
        remain_next   = remain_reg;
        key_next      = key_reg;
        key_pos_next  = key_pos_reg;
        msg_opc_next  = msg_opc_reg;
        in_msg_next   = in_msg_reg;
        err_next      = err_reg;
        len_zero      = 1'b0;

        res_load         = 1'b0;
        res_byte_next    = '0;
        res_present_next = 1'b0;
        res_opc_next     = msg_opc_reg;
        res_fend_next    = 1'b0;
        res_mend_next    = 1'b0;
        res_err_next     = 1'b0;

        if (advance && !err_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    if (is_reserved_opcode(in_byte_reg[OPCODE_W-1:0]))
                    begin
                        err_next     = 1'b1;
                        res_load     = 1'b1;
                        res_opc_next = '0;
                        res_err_next = 1'b1;
                    end
                    else
                    begin
                        fin_next = in_byte_reg[7];
                        if (!in_msg_reg)
                            msg_opc_next = in_byte_reg[OPCODE_W-1:0];
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    masked_next  = in_byte_reg[7];
                    hdr_cnt_next = '0;
                    if (in_byte_reg[6:0] == LEN_CODE_EXT16 ||
                        in_byte_reg[6:0] == LEN_CODE_EXT64)
                    begin
                        ext_long_next = (in_byte_reg[6:0] == LEN_CODE_EXT64);
                        remain_next   = '0;
                        phase_next    = PH_EXTLEN;
                    end
                    else
                    begin
                        ext_long_next = 1'b0;
                        remain_next   = len_t'(in_byte_reg[6:0]);
                        len_zero      = (in_byte_reg[6:0] == 7'd0);
                        key_pos_next  = '0;
                        if (in_byte_reg[7])
                        begin
                            key_next   = '0;
                            phase_next = PH_KEY;
                        end
                        else if (len_zero)
                        begin
                            res_load      = 1'b1;
                            res_fend_next = 1'b1;
                            res_mend_next = fin_reg;
                            in_msg_next   = !fin_reg;
                            phase_next    = PH_HDR0;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_EXTLEN:
                begin
                    remain_next  = ext_len;
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (ext_long_reg ? (hdr_cnt_reg == 3'd7) : (hdr_cnt_reg == 3'd1))
                    begin
                        len_zero     = (ext_len == '0);
                        key_pos_next = '0;
                        if (masked_reg)
                        begin
                            key_next   = '0;
                            phase_next = PH_KEY;
                        end
                        else if (len_zero)
                        begin
                            res_load      = 1'b1;
                            res_fend_next = 1'b1;
                            res_mend_next = fin_reg;
                            in_msg_next   = !fin_reg;
                            phase_next    = PH_HDR0;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte_reg};
                    if (key_pos_reg == 2'd3)
                    begin
                        key_pos_next = '0;
                        if (remain_reg == '0)
                        begin
                            res_load      = 1'b1;
                            res_fend_next = 1'b1;
                            res_mend_next = fin_reg;
                            in_msg_next   = !fin_reg;
                            phase_next    = PH_HDR0;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    else
                        key_pos_next = key_pos_reg + 2'd1;
                end
                PH_PAYLOAD:
                begin
                    res_load         = 1'b1;
                    res_present_next = 1'b1;
                    res_byte_next    = masked_reg ? (in_byte_reg ^ key_byte) : in_byte_reg;
                    if (masked_reg)
                        key_pos_next = key_pos_reg + 2'd1;
                    remain_next = remain_reg - len_t'(1);
                    // Last payload byte of the frame: count was one before this byte
                    if (remain_reg == len_t'(1))
                    begin
                        res_fend_next = 1'b1;
                        res_mend_next = fin_reg;
                        in_msg_next   = !fin_reg;
                        phase_next    = PH_HDR0;
                    end
                end
                default:
                    phase_next = PH_HDR0;
            endcase
        end
    end

    // Input register: take a word whenever the slot is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (stream.ready)
            in_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
            in_byte_reg <= stream.data_byte;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            hdr_cnt_reg  <= '0;
            fin_reg      <= 1'b0;
            masked_reg   <= 1'b0;
            ext_long_reg <= 1'b0;
            remain_reg   <= '0;
            key_reg      <= '0;
            key_pos_reg  <= '0;
            msg_opc_reg  <= '0;
            in_msg_reg   <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            fin_reg      <= fin_next;
            masked_reg   <= masked_next;
            ext_long_reg <= ext_long_next;
            remain_reg   <= remain_next;
            key_reg      <= key_next;
            key_pos_reg  <= key_pos_next;
            msg_opc_reg  <= msg_opc_next;
            in_msg_reg   <= in_msg_next;
            err_reg      <= err_next;
        end
    end

    // Result register: hold while stalled, reload or drop when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_free)
            res_valid_reg <= advance && res_load;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_byte_reg    <= res_byte_next;
            res_present_reg <= res_present_next;
            res_opc_reg     <= res_opc_next;
            res_fend_reg    <= res_fend_next;
            res_mend_reg    <= res_mend_next;
            res_err_reg     <= res_err_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.payload_byte   = res_byte_reg;
    assign result.byte_present   = res_present_reg;
    assign result.message_opcode = res_opc_reg;
    assign result.frame_end      = res_fend_reg;
    assign result.message_end    = res_mend_reg;
    assign result.protocol_error = res_err_reg;

    // Checks
    a_no_word_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !err_reg)
        else $error("result word produced after sticky error");

    a_error_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.protocol_error) |->
            (!result.byte_present && result.message_opcode == '0 && !result.frame_end))
        else $error("error word carries payload fields");

    a_msg_end_in_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.message_end) |-> result.frame_end)
        else $error("message end without frame end");

    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remain_reg != '0))
        else $error("payload phase with zero remaining length");

    a_mark_only_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.byte_present && !result.protocol_error)
            |-> result.frame_end)
        else $error("mark-only word that does not end a frame");

endmodule
